// ----- rtl/core/dcd_pkg.sv -----
// Shared types, constants and the threshold arithmetic of the directional-change detector.
package dcd_pkg;

    localparam int TIME_W  = 48;
    localparam int PRICE_W = 32;
    localparam int INDEX_W = 32;
    localparam int DELTA_W = 16;
    localparam int FRAC_W  = 16;
    localparam int FACTOR_W = FRAC_W + 1;
    localparam int LEVEL_W = PRICE_W + 1;
    localparam int PROD_W  = PRICE_W + FACTOR_W;

    localparam logic [DELTA_W-1:0]  DELTA_RESET = 16'd655;
    localparam logic [FACTOR_W-1:0] FRAC_ONE    = 17'h10000;
    localparam logic [INDEX_W-1:0]  INDEX_MAX   = {INDEX_W{1'b1}};

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One input item: an aggregated tick.
    typedef struct packed {
        logic [TIME_W-1:0]  tick_time;
        logic [PRICE_W-1:0] tick_low;
        logic [PRICE_W-1:0] tick_high;
    } tick_t;

    // One result item: a confirmed reversal.
    typedef struct packed {
        logic               event_down;
        logic [TIME_W-1:0]  extreme_time;
        logic [TIME_W-1:0]  confirm_time;
        logic [PRICE_W-1:0] extreme_price_out;
        logic [PRICE_W-1:0] confirm_price;
        logic [INDEX_W-1:0] extreme_index;
        logic [INDEX_W-1:0] confirm_index;
    } evt_t;

    // A classified tick handed from the front part to the back part.
    typedef struct packed {
        tick_t              tick;
        logic               first;
        logic [INDEX_W-1:0] index;
        logic [LEVEL_W-1:0] level_low;
        logic [LEVEL_W-1:0] level_high;
    } work_t;

    // Reversal level: floor(price * factor / 65536).
    function automatic logic [LEVEL_W-1:0] make_level(
        input logic [PRICE_W-1:0]  price,
        input logic [FACTOR_W-1:0] factor
    );
        logic [PROD_W-1:0] prod;
        begin
            prod = PROD_W'(price) * PROD_W'(factor);
            return prod[PROD_W-1:FRAC_W];
        end
    endfunction

endpackage

// ----- rtl/core/dcd_front.sv -----
// Front part: accepts ticks, numbers them and precomputes both candidate reversal levels.
module dcd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [dcd_pkg::DELTA_W-1:0]  cfg_data,
    input  logic                         tick_valid,
    output logic                         tick_ready,
    input  dcd_pkg::tick_t               tick,
    output logic                         push,
    input  logic                         push_ready,
    output dcd_pkg::work_t               push_data
);

    logic [dcd_pkg::DELTA_W-1:0]  delta_reg;
    logic [dcd_pkg::INDEX_W-1:0]  counter_reg;
    logic [dcd_pkg::INDEX_W-1:0]  counter_next;
    logic                         started_reg;
    logic                         valid_reg;
    logic                         valid_next;
    dcd_pkg::work_t               work_reg;
    dcd_pkg::work_t               work_next;
    logic                         accept;
    logic [dcd_pkg::FACTOR_W-1:0] factor_up;
    logic [dcd_pkg::FACTOR_W-1:0] factor_down;

    // Handshake: the stage takes a tick when empty or when its item moves on.
    assign push       = valid_reg && push_ready;
    assign tick_ready = !valid_reg || push_ready;
    assign accept     = tick_valid && tick_ready;
    assign push_data  = work_reg;

    // Threshold factors for a new extreme in an up or a down phase.
    assign factor_up   = dcd_pkg::FRAC_ONE + dcd_pkg::FACTOR_W'(delta_reg);
    assign factor_down = dcd_pkg::FRAC_ONE - dcd_pkg::FACTOR_W'(delta_reg);

    // Classify the incoming tick.
    always_comb
    begin
        work_next.tick       = tick;
        work_next.first      = !started_reg;
        work_next.index      = counter_reg;
        work_next.level_low  = dcd_pkg::make_level(tick.tick_low, factor_up);
        work_next.level_high = dcd_pkg::make_level(tick.tick_high, factor_down);
        counter_next = (counter_reg == dcd_pkg::INDEX_MAX) ? counter_reg
                                                           : counter_reg + 1'b1;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Control state and the threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg   <= dcd_pkg::DELTA_RESET;
            counter_reg <= '0;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                delta_reg <= cfg_data;
            end
            if (accept)
            begin
                counter_reg <= counter_next;
                started_reg <= 1'b1;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_reg <= work_next;
        end
    end

endmodule

// ----- rtl/core/dcd_queue.sv -----
// Short queue of classified ticks between the front and back parts.
module dcd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            push_ready,
    input  dcd_pkg::work_t  push_data,
    input  logic            pop,
    output logic            head_valid,
    output dcd_pkg::work_t  head
);

    dcd_pkg::work_t              entry_reg [dcd_pkg::QUEUE_DEPTH];
    logic [dcd_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [dcd_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [dcd_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [dcd_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [dcd_pkg::QCNT_W-1:0]  count_reg;
    logic [dcd_pkg::QCNT_W-1:0]  count_next;

    assign push_ready = (count_reg != dcd_pkg::QCNT_W'(dcd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == dcd_pkg::QPTR_W'(dcd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dcd_pkg::QPTR_W'(dcd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/dcd_back.sv -----
// Back part: tracks phase and extreme, confirms reversals and holds the result register.
module dcd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  dcd_pkg::work_t  head,
    output logic            pop,
    output logic            evt_valid,
    input  logic            evt_ready,
    output dcd_pkg::evt_t   evt
);

    logic                          phase_down_reg;
    logic                          phase_down_next;
    logic [dcd_pkg::PRICE_W-1:0]   ext_price_reg;
    logic [dcd_pkg::PRICE_W-1:0]   ext_price_next;
    logic [dcd_pkg::TIME_W-1:0]    ext_time_reg;
    logic [dcd_pkg::TIME_W-1:0]    ext_time_next;
    logic [dcd_pkg::INDEX_W-1:0]   ext_index_reg;
    logic [dcd_pkg::INDEX_W-1:0]   ext_index_next;
    logic [dcd_pkg::LEVEL_W-1:0]   level_reg;
    logic [dcd_pkg::LEVEL_W-1:0]   level_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    dcd_pkg::evt_t                 out_reg;
    dcd_pkg::evt_t                 out_next;
    logic                          emit;
    logic                          new_ext_low;
    logic                          new_ext_high;
    logic [dcd_pkg::PRICE_W-1:0]   lo;
    logic [dcd_pkg::PRICE_W-1:0]   hi;

    assign lo        = head.tick.tick_low;
    assign hi        = head.tick.tick_high;
    assign pop       = head_valid && (!out_valid_reg || evt_ready);
    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    // Decide between a new extreme, a confirmed reversal or nothing.
    always_comb
    begin
        emit         = 1'b0;
        new_ext_low  = 1'b0;
        new_ext_high = 1'b0;
        phase_down_next = phase_down_reg;
        if (head.first)
        begin
            new_ext_low     = 1'b1;
            phase_down_next = 1'b0;
        end
        else if (!phase_down_reg)
        begin
            if (lo < ext_price_reg)
            begin
                new_ext_low = 1'b1;
            end
            else if ({1'b0, hi} >= level_reg)
            begin
                emit            = 1'b1;
                new_ext_high    = 1'b1;
                phase_down_next = 1'b1;
            end
        end
        else
        begin
            if (hi > ext_price_reg)
            begin
                new_ext_high = 1'b1;
            end
            else if ({1'b0, lo} < level_reg)
            begin
                emit            = 1'b1;
                new_ext_low     = 1'b1;
                phase_down_next = 1'b0;
            end
        end
    end

    // Next extreme and result contents.
    always_comb
    begin
        ext_price_next = ext_price_reg;
        ext_time_next  = ext_time_reg;
        ext_index_next = ext_index_reg;
        level_next     = level_reg;
        if (new_ext_low)
        begin
            ext_price_next = lo;
            ext_time_next  = head.tick.tick_time;
            ext_index_next = head.index;
            level_next     = head.level_low;
        end
        else if (new_ext_high)
        begin
            ext_price_next = hi;
            ext_time_next  = head.tick.tick_time;
            ext_index_next = head.index;
            level_next     = head.level_high;
        end

        out_next.event_down        = phase_down_reg;
        out_next.extreme_time      = ext_time_reg;
        out_next.confirm_time      = head.tick.tick_time;
        out_next.extreme_price_out = ext_price_reg;
        out_next.confirm_price     = phase_down_reg ? lo : hi;
        out_next.extreme_index     = ext_index_reg;
        out_next.confirm_index     = head.index;

        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (evt_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_down_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_down_reg <= phase_down_next;
            end
        end
    end

    // Extreme tracking and result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ext_price_reg <= ext_price_next;
            ext_time_reg  <= ext_time_next;
            ext_index_reg <= ext_index_next;
            level_reg     <= level_next;
        end
        if (pop && emit)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- rtl/core/directional_change_detector.sv -----
// Top level of the directional-change detector: front part, queue and back part.
//
//  Channel   Signals                          Direction  Content
//  tick      tick_valid, tick_ready, tick     in         one aggregated tick per item
//  evt       evt_valid, evt_ready, evt        out        one confirmed reversal per item
//  cfg       cfg_we, cfg_data                 in         reversal threshold, written at once
//
// One tick per cycle is sustained while evt does not stall. A result passes the front
// stage with the level multipliers, then a queue entry, then the result register.
// The reversal-state update in the back part closes its loop through its own registers.
// Reset clears the tick counter, phase and all valid flags, and loads the threshold 655.
// A stall on evt backs up into the queue; tick_ready drops only when the queue is full.
module directional_change_detector (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [dcd_pkg::DELTA_W-1:0]  cfg_data,
    input  logic                         tick_valid,
    output logic                         tick_ready,
    input  dcd_pkg::tick_t               tick,
    output logic                         evt_valid,
    input  logic                         evt_ready,
    output dcd_pkg::evt_t                evt
);

    logic            push;
    logic            push_ready;
    dcd_pkg::work_t  push_data;
    logic            pop;
    logic            head_valid;
    dcd_pkg::work_t  head;

    // Front part: numbering and level precomputation.
    dcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue.
    dcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back part: reversal tracking and result register.
    dcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt)
    );

endmodule

// ----- dv/directional_change_detector_checker.sv -----
`timescale 1ns / 100ps
// Checker for the directional-change detector: trend tracking, expected reversals and compares.
module directional_change_detector_checker
    import dcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [DELTA_W-1:0] cfg_data,
    input  logic               tick_valid,
    input  logic               tick_ready,
    input  tick_t              tick,
    input  logic               evt_valid,
    input  logic               evt_ready,
    input  evt_t               evt,
    output int                 fail_count,
    output int                 pending_events,
    output int                 ticks_seen,
    output int                 up_events,
    output int                 down_events
);

    // Our own copy of the trend state and the threshold register.
    logic [DELTA_W-1:0] delta_now = DELTA_RESET;
    logic               trend_started;
    logic               trend_down;
    logic [PRICE_W-1:0] peak_price;
    logic [TIME_W-1:0]  peak_stamp;
    logic [INDEX_W-1:0] peak_index;
    logic [LEVEL_W-1:0] reversal_level;
    logic [INDEX_W-1:0] next_index;

    // Reversals predicted but not yet seen on the output, oldest first.
    evt_t expected_reversals[$];

    // Threshold for the given phase: floor(price * (1 +/- delta) ), 16 fraction bits.
    function automatic logic [LEVEL_W-1:0] level_for(input logic [PRICE_W-1:0] price,
                                                     input logic down);
        logic [16:0] factor;
        logic [63:0] prod;
        factor = down ? (17'h10000 - {1'b0, delta_now}) : (17'h10000 + {1'b0, delta_now});
        prod = {32'b0, price} * {47'b0, factor};
        return prod[48:16];
    endfunction

    // Take a new extreme; the level is recomputed with the current delta and phase.
    task automatic set_peak(input logic [PRICE_W-1:0] price, input logic [TIME_W-1:0] stamp,
                            input logic [INDEX_W-1:0] index);
        peak_price = price;
        peak_stamp = stamp;
        peak_index = index;
        reversal_level = level_for(price, trend_down);
    endtask

    // Advance the trend state by one tick and queue any reversal it confirms.
    task automatic follow_tick(input tick_t t);
        logic [INDEX_W-1:0] index;
        evt_t rev;
        index = next_index;
        if (next_index != INDEX_MAX)
            next_index = next_index + 1'b1;
        rev.extreme_time = peak_stamp;
        rev.confirm_time = t.tick_time;
        rev.extreme_price_out = peak_price;
        rev.extreme_index = peak_index;
        rev.confirm_index = index;
        if (!trend_started)
        begin
            // The very first tick opens an up phase at its low.
            trend_started = 1'b1;
            trend_down = 1'b0;
            set_peak(t.tick_low, t.tick_time, index);
        end
        else if (!trend_down)
        begin
            if (t.tick_low < peak_price)
                set_peak(t.tick_low, t.tick_time, index);
            else if ({1'b0, t.tick_high} >= reversal_level)
            begin
                rev.event_down = 1'b0;
                rev.confirm_price = t.tick_high;
                expected_reversals.insert(expected_reversals.size(), rev);
                up_events++;
                trend_down = 1'b1;
                set_peak(t.tick_high, t.tick_time, index);
            end
        end
        else
        begin
            if (t.tick_high > peak_price)
                set_peak(t.tick_high, t.tick_time, index);
            else if ({1'b0, t.tick_low} < reversal_level)
            begin
                rev.event_down = 1'b1;
                rev.confirm_price = t.tick_low;
                expected_reversals.insert(expected_reversals.size(), rev);
                down_events++;
                trend_down = 1'b0;
                set_peak(t.tick_low, t.tick_time, index);
            end
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare an output item with the oldest predicted reversal.
    task automatic check_reversal(input evt_t got);
        evt_t want;
        if (expected_reversals.size() == 0)
        begin
            $display("%0t: reversal item expected none, actual %h", $time, got);
            fail_count++;
        end
        else
        begin
            want = expected_reversals.pop_front();
            check_field("event_down", want.event_down, got.event_down);
            check_field("extreme_time", want.extreme_time, got.extreme_time);
            check_field("confirm_time", want.confirm_time, got.confirm_time);
            check_field("extreme_price_out", want.extreme_price_out, got.extreme_price_out);
            check_field("confirm_price", want.confirm_price, got.confirm_price);
            check_field("extreme_index", want.extreme_index, got.extreme_index);
            check_field("confirm_index", want.confirm_index, got.confirm_index);
        end
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_now = DELTA_RESET;
            trend_started = 1'b0;
            trend_down = 1'b0;
            peak_price = '0;
            peak_stamp = '0;
            peak_index = '0;
            reversal_level = '0;
            next_index = '0;
            expected_reversals.delete();
            pending_events = 0;
        end
        else
        begin
            if (evt_valid && evt_ready)
                check_reversal(evt);
            if (tick_valid && tick_ready)
            begin
                ticks_seen++;
                follow_tick(tick);
            end
            if (cfg_we)
                delta_now = cfg_data;
            pending_events = expected_reversals.size();
        end
    end

endmodule

// ----- dv/directional_change_detector_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the directional-change detector: clock, reset, stimulus and verdict.
module directional_change_detector_test;
    import dcd_pkg::*;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 155;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam longint PRICE_CEIL = 64'h0000_0000_FFFF_FFFF;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [DELTA_W-1:0] cfg_data;
    logic               tick_valid;
    logic               tick_ready;
    tick_t              tick;
    logic               evt_valid;
    logic               evt_ready;
    evt_t               evt;

    int fail_count;
    int pending_events;
    int ticks_seen;
    int up_events;
    int down_events;
    int cycle_count;
    int settings_used;

    // Shared between the sender and the receiver.
    bit quiet;
    bit hold_request;

    // Random-walk state of the price generator.
    logic [DELTA_W-1:0] cur_delta;
    longint             walk_price;
    logic [TIME_W-1:0]  walk_time;

    directional_change_detector u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt)
    );

    directional_change_detector_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .tick_valid     (tick_valid),
        .tick_ready     (tick_ready),
        .tick           (tick),
        .evt_valid      (evt_valid),
        .evt_ready      (evt_ready),
        .evt            (evt),
        .fail_count     (fail_count),
        .pending_events (pending_events),
        .ticks_seen     (ticks_seen),
        .up_events      (up_events),
        .down_events    (down_events)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit, counted in clock cycles.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none when quiet.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                evt_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                evt_ready <= 1'b1;
                hold_request = 1'b0;
            end
            else if (quiet)
                evt_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                evt_ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                evt_ready <= 1'b0;
            end
            else
                evt_ready <= 1'b1;
        end
    end

    function automatic tick_t make_tick(input logic [TIME_W-1:0] stamp,
                                        input logic [PRICE_W-1:0] lo,
                                        input logic [PRICE_W-1:0] hi);
        tick_t t;
        t.tick_time = stamp;
        t.tick_low = lo;
        t.tick_high = hi;
        return t;
    endfunction

    // Level at which a phase reverses, used to aim directed ticks at the boundary.
    function automatic logic [PRICE_W-1:0] boundary_of(input logic [PRICE_W-1:0] price,
                                                      input logic down,
                                                      input logic [DELTA_W-1:0] d);
        logic [63:0] prod;
        prod = {32'b0, price} * (down ? (64'h10000 - d) : (64'h10000 + d));
        return prod[47:16];
    endfunction

    // Offer one item, after a random gap unless idling is off; return at a falling edge.
    task automatic send_tick(input tick_t t);
        int gap;
        gap = 0;
        if (!quiet && !hold_request && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick <= t;
        tick_valid <= 1'b1;
        do
            @(posedge clk);
        while (!tick_ready);
        @(negedge clk);
    endtask

    // Next random tick: mostly a price walk scaled to the threshold, some noise.
    task automatic walk_tick(output tick_t t);
        int unsigned kind;
        longint span;
        longint price;
        longint lo_val;
        longint hi_val;
        kind = $urandom_range(0, 99);
        walk_time = walk_time + TIME_W'($urandom_range(1, 1000));
        if (kind < 8)
        begin
            // Noise over the full range of every field.
            t.tick_time = {16'($urandom()), $urandom()};
            t.tick_low = $urandom();
            t.tick_high = $urandom();
        end
        else
        begin
            if (kind >= 10 && kind < 13)
            begin
                if ($urandom_range(0, 3) == 0)
                    walk_price = $urandom_range(16, 4096);
                else
                    walk_price = $urandom_range(32'h0010_0000, 32'h4000_0000);
            end
            span = ((walk_price * (longint'(cur_delta) + 32)) >>> 17) + 1;
            if (span > 64'h3FFF_FFFF)
                span = 64'h3FFF_FFFF;
            price = walk_price + longint'($urandom_range(0, 32'(2 * span))) - span;
            if (price < 16)
                price = 16;
            if (price > PRICE_CEIL)
                price = PRICE_CEIL;
            walk_price = price;
            lo_val = price - longint'($urandom_range(0, 32'(span >>> 2)));
            hi_val = price + longint'($urandom_range(0, 32'(span >>> 2)));
            if (lo_val < 0)
                lo_val = 0;
            if (hi_val > PRICE_CEIL)
                hi_val = PRICE_CEIL;
            t.tick_time = walk_time;
            // A few walk ticks come inverted, low above high.
            if (kind < 10)
            begin
                t.tick_low = hi_val[31:0];
                t.tick_high = lo_val[31:0];
            end
            else
            begin
                t.tick_low = lo_val[31:0];
                t.tick_high = hi_val[31:0];
            end
        end
    endtask

    // Stop offering, wait for every expected reversal, then let the pipeline empty.
    task automatic settle();
        tick_valid <= 1'b0;
        while (pending_events != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_delta(input logic [DELTA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_data <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_delta = d;
        settings_used++;
    endtask

    // Main stimulus: reset, directed ticks, then random phases under several thresholds.
    initial
    begin
        logic [DELTA_W-1:0] phase_delta [PHASES];
        logic [PRICE_W-1:0] base_a;
        logic [PRICE_W-1:0] base_b;
        logic [PRICE_W-1:0] up_lvl;
        logic [PRICE_W-1:0] dn_lvl;
        tick_t t;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        tick_valid = 1'b0;
        tick = '0;
        evt_ready = 1'b0;
        quiet = 1'b0;
        hold_request = 1'b0;
        cur_delta = DELTA_RESET;
        settings_used = 1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed ticks under the reset threshold.
        base_a = 32'd256000;
        base_b = base_a - 32'd512;
        up_lvl = boundary_of(base_b, 1'b0, DELTA_RESET);
        dn_lvl = boundary_of(up_lvl, 1'b1, DELTA_RESET);
        // First tick opens the up phase and gives no item.
        send_tick(make_tick(48'd0, base_a, base_a + 32'd2560));
        send_tick(make_tick(48'd1000, base_b, base_a));
        // One below the up level, then exactly on it.
        send_tick(make_tick(48'd2000, base_b, up_lvl - 1'b1));
        send_tick(make_tick(48'd3000, base_b, up_lvl));
        // High equal to the extreme and low equal to the level: no reversal.
        send_tick(make_tick(48'd4000, dn_lvl, up_lvl));
        send_tick(make_tick(48'd5000, dn_lvl - 1'b1, up_lvl - 1'b1));
        // Zero prices, then the top of the price range.
        send_tick(make_tick(48'd6000, '0, '0));
        send_tick(make_tick(48'd7000, '0, '0));
        send_tick(make_tick(48'd8000, '0, '1));
        send_tick(make_tick(48'd9000, '1, '1));
        // Inverted ticks, one reversing and one not.
        send_tick(make_tick(48'd10000, 32'h8000_0000, 32'h0000_0010));
        send_tick(make_tick(48'd11000, '1, 32'h0000_0001));
        send_tick(make_tick('1, '1, '1));
        // Tiny prices, where the truncated level equals or falls below the extreme.
        send_tick(make_tick(48'd5, 32'd1, 32'd1));
        send_tick(make_tick(48'd6, 32'd1, 32'd1));
        send_tick(make_tick(48'd7, 32'd0, 32'd1));
        settle();

        phase_delta[0] = 16'd0;
        phase_delta[1] = 16'hFFFF;
        phase_delta[2] = 16'($urandom());
        phase_delta[3] = 16'($urandom_range(1, 2000));
        phase_delta[4] = 16'd1;
        phase_delta[5] = 16'($urandom_range(100, 3000));
        walk_price = base_a;
        walk_time = 48'd20000;

        for (int p = 0; p < PHASES; p++)
        begin
            write_delta(phase_delta[p]);
            quiet = (p == PHASES - 1);
            // With a zero threshold these ticks reverse every time; hold the output
            // so that the block backs up and stalls its input.
            if (p == 0)
            begin
                hold_request = 1'b1;
                repeat (24)
                begin
                    walk_time = walk_time + 1'b1;
                    send_tick(make_tick(walk_time, 32'h0000_1000, 32'h0000_2000));
                end
            end
            repeat (PHASE_ITEMS)
            begin
                walk_tick(t);
                send_tick(t);
            end
            settle();
        end

        $display("Run covered %0d ticks and %0d reversals (%0d up, %0d down).",
                 ticks_seen, up_events + down_events, up_events, down_events);
        $display("Thresholds used: %0d settings, including zero and full scale.",
                 settings_used);
        if (fail_count == 0 && pending_events == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/dcd_pkg.sv
rtl/core/dcd_front.sv
rtl/core/dcd_queue.sv
rtl/core/dcd_back.sv
rtl/core/directional_change_detector.sv
dv/directional_change_detector_checker.sv
dv/directional_change_detector_test.sv
